### sv/running_median_abs_deviation_top_macros.svh
// Assertion macros shared by the running median block.
// Included by rmad_back, which carries the concurrent checks; depends on clk and rst_n.
`ifndef RUNNING_MEDIAN_ABS_DEVIATION_TOP_MACROS_SVH
`define RUNNING_MEDIAN_ABS_DEVIATION_TOP_MACROS_SVH

// property checked on every rising clk edge outside reset
`define RMAD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression that must never be true
`define RMAD_NEVER(lbl, expr, msg) \
    `RMAD_ASSERT(lbl, !(expr), msg)

`endif

### sv/rmad_pkg.sv
// Shared types and constants of the running median block.
// No dependencies; used by rmad_front, rmad_back and the top level.
`timescale 1ns / 1ps
`default_nettype none
package rmad_pkg;

    localparam int CAPACITY    = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int EFF_W       = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int QDEPTH      = 2;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] value;
        logic signed [31:0] offset;
    } item_t;

endpackage
`default_nettype wire

### sv/rmad_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rmad_ram #(
    parameter int W = 32,
    parameter int D = 512
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [$clog2(D)-1:0] waddr,
    input  wire logic [W-1:0]         wdata,
    input  wire logic [$clog2(D)-1:0] raddr,
    output logic      [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### sv/rmad_front.sv
// Front end: takes command words and holds them in a short queue for the back end.
// Depends on rmad_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmad_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire rmad_pkg::item_t in_item,
    output logic                 busy,
    output rmad_pkg::item_t      item,
    output logic                 item_valid,
    input  wire logic            pop
);
    rmad_pkg::item_t q_reg [rmad_pkg::QDEPTH];
    logic            wp_reg, wp_next;
    logic            rp_reg, rp_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            push, take;

    assign busy       = (cnt_reg == 2'(rmad_pkg::QDEPTH));
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rp_reg];
    assign push       = start && !busy;
    assign take       = pop && item_valid;

    always_comb
    begin
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = take ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(take);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

### sv/rmad_back.sv
// Back end: sorted value store, insert sequencer, running sums and query results.
// Depends on rmad_pkg, rmad_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "running_median_abs_deviation_top_macros.svh"
module rmad_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rmad_pkg::item_t item,
    input  wire logic            item_valid,
    output logic                 pop,
    output logic                 done,
    output logic signed [31:0]   median,
    output logic signed [63:0]   min_total,
    output logic                 empty_res,
    output logic                 overflowed
);
    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_RD_R    = 7'b0000010,
        S_CALC    = 7'b0000100,
        S_SCAN    = 7'b0001000,
        S_PUT     = 7'b0010000,
        S_MED     = 7'b0100000,
        S_MED_CAP = 7'b1000000
    } state_t;

    localparam int EW = rmad_pkg::EFF_W;
    localparam int IW = rmad_pkg::IDX_W;
    localparam int CW = rmad_pkg::CNT_W;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic signed [EW-1:0]     med_reg, med_next;
    logic [63:0]              dev_reg, dev_next;
    logic signed [63:0]       off_reg, off_next;
    logic                     ovf_reg, ovf_next;
    logic signed [EW-1:0]     a_reg, a_next;
    logic signed [EW-1:0]     l_reg, l_next;
    logic [IW-1:0]            j_reg, j_next;
    logic [IW-1:0]            pos_reg, pos_next;
    logic                     done_reg, done_next;
    logic signed [31:0]       med_out_reg, med_out_next;
    logic signed [63:0]       tot_reg, tot_next;
    logic                     emp_reg, emp_next;
    logic                     ovo_reg, ovo_next;

    logic                     we;
    logic [IW-1:0]            waddr, raddr;
    logic [EW-1:0]            wdata, rdata;
    logic signed [EW-1:0]     rd_s;

    logic [CW-1:0]            ml_full;
    logic [IW-1:0]            ml;
    logic signed [EW:0]       diff_l, diff_r;
    logic [EW:0]              dist_l, dist_r, gap;
    logic                     use_dist;
    logic [64:0]              dev_sum;
    logic signed [64:0]       off_sum, tot_sum;
    logic signed [EW-1:0]     in_val;

    assign rd_s    = $signed(rdata);
    assign in_val  = $signed(item.value[EW-1:0]);
    assign ml_full = ((cnt_reg + CW'(1)) >> 1) - CW'(1);
    assign ml      = ml_full[IW-1:0];

    rmad_ram #(.W(EW), .D(rmad_pkg::CAPACITY)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // distance of the new value to the lower and upper middle elements
    always_comb
    begin
        diff_l = (EW+1)'(a_reg) - (EW+1)'(l_reg);
        diff_r = (EW+1)'(a_reg) - (EW+1)'(rd_s);
        dist_l = diff_l[EW] ? $unsigned(-diff_l) : $unsigned(diff_l);
        dist_r = diff_r[EW] ? $unsigned(-diff_r) : $unsigned(diff_r);
        if (cnt_reg[0])
        begin
            use_dist = 1'b1;
            gap      = dist_l;
        end
        else if (a_reg < l_reg)
        begin
            use_dist = 1'b1;
            gap      = dist_l;
        end
        else if (a_reg > rd_s)
        begin
            use_dist = 1'b1;
            gap      = dist_r;
        end
        else
        begin
            use_dist = 1'b0;
            gap      = '0;
        end
        dev_sum = {1'b0, dev_reg} + 65'(gap);
        off_sum = 65'(off_reg) + 65'(item.offset);
        tot_sum = $signed({1'b0, dev_reg}) + 65'(off_reg);
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        med_next     = med_reg;
        dev_next     = dev_reg;
        off_next     = off_reg;
        ovf_next     = ovf_reg;
        a_next       = a_reg;
        l_next       = l_reg;
        j_next       = j_reg;
        pos_next     = pos_reg;
        done_next    = 1'b0;
        med_out_next = med_out_reg;
        tot_next     = tot_reg;
        emp_next     = emp_reg;
        ovo_next     = ovo_reg;
        pop          = 1'b0;
        we           = 1'b0;
        waddr        = pos_reg;
        wdata        = a_reg;
        raddr        = ml;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    pop = 1'b1;
                    if (item.req_type == rmad_pkg::REQ_QUERY)
                    begin
                        done_next = 1'b1;
                        emp_next  = (cnt_reg == '0);
                        ovo_next  = ovf_reg;
                        if (cnt_reg == '0)
                        begin
                            med_out_next = '0;
                            tot_next     = '0;
                        end
                        else
                        begin
                            med_out_next = 32'(med_reg);
                            if (tot_sum[64] != tot_sum[63])
                            begin
                                tot_next = tot_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                            end
                            else
                            begin
                                tot_next = tot_sum[63:0];
                            end
                        end
                    end
                    else if (cnt_reg == CW'(rmad_pkg::CAPACITY))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        a_next = in_val;
                        if (off_sum[64] != off_sum[63])
                        begin
                            off_next = off_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                        end
                        else
                        begin
                            off_next = off_sum[63:0];
                        end
                        if (cnt_reg == '0)
                        begin
                            pos_next   = '0;
                            state_next = S_PUT;
                        end
                        else
                        begin
                            state_next = S_RD_R;
                        end
                    end
                end
            end
            S_RD_R:
            begin
                l_next     = rd_s;
                raddr      = ml + IW'(1);
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (use_dist)
                begin
                    dev_next = (dev_sum[64:63] != 2'b00) ? {1'b0, {63{1'b1}}} : dev_sum[63:0];
                end
                raddr      = IW'(cnt_reg - CW'(1));
                j_next     = IW'(cnt_reg - CW'(1));
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // rdata holds entry j; larger entries move up one place
                we    = 1'b1;
                waddr = j_reg + IW'(1);
                raddr = j_reg - IW'(1);
                if (rd_s > a_reg)
                begin
                    wdata = rdata;
                    if (j_reg == '0)
                    begin
                        pos_next   = '0;
                        state_next = S_PUT;
                    end
                    else
                    begin
                        j_next = j_reg - IW'(1);
                    end
                end
                else
                begin
                    wdata      = a_reg;
                    state_next = S_MED;
                end
            end
            S_PUT:
            begin
                we         = 1'b1;
                state_next = S_MED;
            end
            S_MED:
            begin
                raddr      = IW'(cnt_reg >> 1);
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_MED_CAP;
            end
            S_MED_CAP:
            begin
                med_next   = rd_s;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        l_reg       <= l_next;
        j_reg       <= j_next;
        pos_reg     <= pos_next;
        med_out_reg <= med_out_next;
        tot_reg     <= tot_next;
        emp_reg     <= emp_next;
        ovo_reg     <= ovo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            med_reg   <= '0;
            dev_reg   <= '0;
            off_reg   <= '0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            med_reg   <= med_next;
            dev_reg   <= dev_next;
            off_reg   <= off_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
        end
    end

    assign done       = done_reg;
    assign median     = med_out_reg;
    assign min_total  = tot_reg;
    assign empty_res  = emp_reg;
    assign overflowed = ovo_reg;

    `RMAD_ASSERT(a_done_after_query, done_reg |-> $past(pop && item.req_type), "result without query")
    `RMAD_NEVER(a_cnt_in_range, cnt_reg > CW'(rmad_pkg::CAPACITY), "count above capacity")
    `RMAD_NEVER(a_dev_nonneg, dev_reg[63], "deviation sum left positive range")
    `RMAD_NEVER(a_scan_room, (state_reg == S_SCAN) && (cnt_reg == CW'(rmad_pkg::CAPACITY)), "shift on full store")
endmodule
`default_nettype wire

### sv/running_median_abs_deviation_top.sv
// Top level of the running median / absolute deviation block.
// Depends on rmad_pkg, rmad_front, rmad_back (with rmad_ram inside).
//
// channel   direction  handshake        word
// command   in         start / busy     req_type, value, offset
// result    out        done (strobe)    median, min_total, empty_res, overflowed
//
// A query is handled in S_IDLE; its result shows in the next cycle.
// An update reads the middle pair in S_RD_R and S_CALC, shifts larger values
// up one entry per cycle in S_SCAN and reads the new median in S_MED_CAP;
// on an empty store it goes to S_PUT; an update on a full store is dropped.
// The two-word command queue takes start while the back end works, until full.
// rst_n clears counts and sums at once; store contents need no clearing.
// Results cannot be held off: done is high for exactly one cycle per query.
`timescale 1ns / 1ps
`default_nettype none
module running_median_abs_deviation_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                req_type,
    input  wire logic signed [31:0]  value,
    input  wire logic signed [31:0]  offset,
    output logic                     done,
    output logic signed [31:0]       median,
    output logic signed [63:0]       min_total,
    output logic                     empty_res,
    output logic                     overflowed
);
    rmad_pkg::item_t in_item;
    rmad_pkg::item_t q_item;
    logic            q_valid;
    logic            q_pop;

    // pack the command word for the queue
    always_comb
    begin
        in_item.req_type = req_type;
        in_item.value    = value;
        in_item.offset   = offset;
    end

    // front: command queue
    rmad_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .in_item    (in_item),
        .busy       (busy),
        .item       (q_item),
        .item_valid (q_valid),
        .pop        (q_pop)
    );

    // back: sorted store, sums, results
    rmad_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (q_item),
        .item_valid (q_valid),
        .pop        (q_pop),
        .done       (done),
        .median     (median),
        .min_total  (min_total),
        .empty_res  (empty_res),
        .overflowed (overflowed)
    );
endmodule
`default_nettype wire
